// ===== rtl/tamr_pkg.sv =====
// ============================================================================
// Tensor axis mean reducer package
// Shared constants, configuration register codes and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package tamr_pkg;

    // Width of the mean output field.
    localparam int MEAN_W = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Widths of the individual configuration registers.
    localparam int INNER_CFG_W = 9;
    localparam int COUNT_CFG_W = 11;
    localparam int OUTER_CFG_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a sample transaction completes this cycle
        logic div_step;  // run one divider iteration
        logic out_load;  // move the quotient into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emits;     // the sample at the current position completes a mean
        logic out_free;  // the output register can take a new result
    } t_dp_status;

endpackage

// ===== rtl/tamr_ctrl.sv =====
// ============================================================================
// Tensor axis mean reducer controller
// Sequences sample acceptance, the iterative divider and the output load.
// ============================================================================
module tamr_ctrl import tamr_pkg::*; #(
    parameter int ACC_W = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int STEP_W = $clog2(ACC_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    // Next-state logic and command decode.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid && i_status.emits) begin
                    n_state = ST_DIV;
                    n_step  = STEP_W'(ACC_W - 1);
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_LOAD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/tamr_datapath.sv =====
// ============================================================================
// Tensor axis mean reducer datapath
// Holds the configuration, the position counters, the accumulator memory,
// the restoring divider and the output register.
// ============================================================================
module tamr_datapath import tamr_pkg::*; #(
    parameter int INNER_MAX   = 256,
    parameter int COUNT_MAX   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [MEAN_W-1:0]      o_mean,
    output logic                          o_tensor_done
);

    localparam int IDX_W    = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int IN_W     = $clog2(INNER_MAX + 1);
    localparam int RED_W    = (COUNT_MAX > 1) ? $clog2(COUNT_MAX) : 1;
    localparam int CNT_W    = $clog2(COUNT_MAX + 1);
    localparam int OUT_BITS = (SAMPLE_BITS < MEAN_W) ? SAMPLE_BITS : MEAN_W;

    // Configuration and position registers.
    logic [IN_W-1:0]        r_inner_len;
    logic [CNT_W-1:0]       r_count;
    logic [OUTER_CFG_W-1:0] r_outer_len;
    logic [IDX_W-1:0]       r_inner_pos;
    logic [IDX_W-1:0]       n_inner_pos;
    logic [RED_W-1:0]       r_red_pos;
    logic [RED_W-1:0]       n_red_pos;
    logic [OUTER_CFG_W-1:0] r_outer_pos;
    logic [OUTER_CFG_W-1:0] n_outer_pos;

    // Accumulator memory and its registered read port.
    logic signed [ACC_W-1:0] r_acc_mem [INNER_MAX];
    logic signed [ACC_W-1:0] r_rd_data;
    logic signed [ACC_W-1:0] sample_ext;
    logic signed [ACC_W-1:0] acc_sum;
    logic [ACC_W-1:0]        sum_mag;

    // Divider and output registers.
    logic [ACC_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic                    r_neg;
    logic                    r_flag;
    logic [CNT_W:0]          div_shift;
    logic [CNT_W:0]          div_diff;
    logic                    div_fits;
    logic [ACC_W-1:0]        quo_signed;
    logic                    r_valid;
    logic [MEAN_W-1:0]       r_mean;
    logic                    r_tensor_done;

    logic [INNER_CFG_W-1:0]  cfg_inner_raw;
    logic [COUNT_CFG_W-1:0]  cfg_count_raw;
    logic [OUTER_CFG_W-1:0]  cfg_outer_raw;
    logic [IN_W-1:0]         cfg_inner_val;
    logic [CNT_W-1:0]        cfg_count_val;
    logic [OUTER_CFG_W-1:0]  cfg_outer_val;
    logic                    cfg_known;
    logic                    last_inner;
    logic                    last_red;
    logic                    last_outer;

    // Register values: zero acts as one, oversized values saturate.
    always_comb begin
        cfg_inner_raw = i_cfg_data[INNER_CFG_W-1:0];
        cfg_count_raw = i_cfg_data[COUNT_CFG_W-1:0];
        cfg_outer_raw = i_cfg_data[OUTER_CFG_W-1:0];
        if (cfg_inner_raw == '0) begin
            cfg_inner_val = IN_W'(1);
        end else if (32'(cfg_inner_raw) > INNER_MAX) begin
            cfg_inner_val = IN_W'(INNER_MAX);
        end else begin
            cfg_inner_val = IN_W'(cfg_inner_raw);
        end
        if (cfg_count_raw == '0) begin
            cfg_count_val = CNT_W'(1);
        end else if (32'(cfg_count_raw) > COUNT_MAX) begin
            cfg_count_val = CNT_W'(COUNT_MAX);
        end else begin
            cfg_count_val = CNT_W'(cfg_count_raw);
        end
        cfg_outer_val = (cfg_outer_raw == '0) ? OUTER_CFG_W'(1) : cfg_outer_raw;
        cfg_known = i_cfg_valid && ((i_cfg_index == CFG_INNER) ||
                                    (i_cfg_index == CFG_COUNT) ||
                                    (i_cfg_index == CFG_OUTER));
    end

    // End-of-range flags for the three nested positions.
    assign last_inner = (IN_W'(r_inner_pos) + IN_W'(1)) >= r_inner_len;
    assign last_red   = (CNT_W'(r_red_pos) + CNT_W'(1)) >= r_count;
    assign last_outer = ({1'b0, r_outer_pos} + (OUTER_CFG_W + 1)'(1)) >=
                        {1'b0, r_outer_len};

    // Position update: a known register write starts a new tensor.
    always_comb begin
        n_inner_pos = r_inner_pos;
        n_red_pos   = r_red_pos;
        n_outer_pos = r_outer_pos;
        if (cfg_known) begin
            n_inner_pos = '0;
            n_red_pos   = '0;
            n_outer_pos = '0;
        end else if (i_cmd.accept) begin
            if (!last_inner) begin
                n_inner_pos = r_inner_pos + IDX_W'(1);
            end else begin
                n_inner_pos = '0;
                if (!last_red) begin
                    n_red_pos = r_red_pos + RED_W'(1);
                end else begin
                    n_red_pos = '0;
                    n_outer_pos = last_outer ? '0 : r_outer_pos + OUTER_CFG_W'(1);
                end
            end
        end
    end

    // Accumulate: the first reduced slice overwrites, later slices add.
    assign sample_ext = ACC_W'(i_sample);
    assign acc_sum    = (r_red_pos == '0) ? sample_ext : r_rd_data + sample_ext;
    assign sum_mag    = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);

    // One restoring division step on the magnitude.
    assign div_shift  = {r_rem, r_quo[ACC_W-1]};
    assign div_diff   = div_shift - {1'b0, r_count};
    assign div_fits   = div_shift >= {1'b0, r_count};
    assign quo_signed = r_neg ? (~r_quo + ACC_W'(1)) : r_quo;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len  <= IN_W'(1);
            r_count      <= CNT_W'(1);
            r_outer_len  <= OUTER_CFG_W'(1);
            r_inner_pos  <= '0;
            r_red_pos    <= '0;
            r_outer_pos  <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_INNER)) begin
                r_inner_len <= cfg_inner_val;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_COUNT)) begin
                r_count <= cfg_count_val;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_OUTER)) begin
                r_outer_len <= cfg_outer_val;
            end
            r_inner_pos <= n_inner_pos;
            r_red_pos   <= n_red_pos;
            r_outer_pos <= n_outer_pos;
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Accumulator memory, read ahead at the next position with write bypass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc_mem[r_inner_pos] <= acc_sum;
        end
        if (i_cmd.accept && (n_inner_pos == r_inner_pos)) begin
            r_rd_data <= acc_sum;
        end else begin
            r_rd_data <= r_acc_mem[n_inner_pos];
        end
    end

    // Divider operands, iterations and the output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_quo  <= sum_mag;
            r_rem  <= '0;
            r_neg  <= acc_sum[ACC_W-1];
            r_flag <= last_inner && last_outer;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ACC_W-2:0], div_fits};
            r_rem <= CNT_W'(div_fits ? div_diff : div_shift);
        end
        if (i_cmd.out_load) begin
            r_mean        <= MEAN_W'(quo_signed[OUT_BITS-1:0]);
            r_tensor_done <= r_flag;
        end
    end

    assign o_status.emits    = last_red;
    assign o_status.out_free = !r_valid || !i_stall;
    assign o_valid           = r_valid;
    assign o_mean            = r_mean;
    assign o_tensor_done     = r_tensor_done;

endmodule

// ===== rtl/tensor_axis_mean_reducer_unit.sv =====
// ============================================================================
// Tensor axis mean reducer
// Streams tensor elements and emits their mean over a range of reduced axes.
// ============================================================================
// Samples enter one per transaction in row-major order; the block keeps one
// accumulator per inner position in an on-chip memory and, on the last
// reduced slice, emits sum / count truncated toward zero, with o_tensor_done
// set on the final mean of the tensor. Samples that complete no mean stream
// at one per cycle while no mean is being divided or loaded. A sample that
// completes a mean holds the input stalled while the restoring divider runs
// its ACC_W iterations at one bit per cycle and then until the quotient is
// loaded into the output register, which waits while the output is stalled.
// A register write resets all positions and starts a new tensor; write
// registers only while the block is idle. The accumulator memory needs no
// clearing after reset.
module tensor_axis_mean_reducer_unit import tamr_pkg::*; #(
    parameter int INNER_MAX   = 256,
    parameter int COUNT_MAX   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [MEAN_W-1:0]      o_mean,
    output logic                          o_tensor_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // The sum of COUNT_MAX samples fits this signed width.
    localparam int ACC_W = SAMPLE_BITS + $clog2(COUNT_MAX);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    tamr_ctrl #(
        .ACC_W (ACC_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    tamr_datapath #(
        .INNER_MAX   (INNER_MAX),
        .COUNT_MAX   (COUNT_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_sample      (i_sample),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_mean        (o_mean),
        .o_tensor_done (o_tensor_done)
    );

    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> dp_status.out_free)
        else $error("mean loaded while the output register was occupied");

    // A sample that completes a mean blocks the input while dividing.
    a_stall_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.accept && dp_status.emits) |=> o_stall)
        else $error("input not stalled while the divider runs");

    // A loaded result appears on the output in the next cycle.
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |=> o_valid)
        else $error("loaded mean not presented on the output");

    // The divider never iterates in a cycle that accepts a sample.
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.accept && dp_cmd.div_step))
        else $error("sample accepted while the divider iterates");

endmodule

// ===== test/tensor_axis_mean_reducer_unit_test.sv =====
// ============================================================================
// Tensor axis mean reducer testbench
// Streams signed Q8.8 tensor elements through the reducer under several size
// settings, predicts every mean and tensor-done flag in a scoreboard class,
// and compares each result transaction with the oldest prediction. Both sides
// idle and stall at random, and one long output stall backs up the input.
// ============================================================================
module tensor_axis_mean_reducer_unit_test;
    import tamr_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam int INNER_LIMIT    = 256;
    localparam int COUNT_LIMIT    = 1024;
    localparam int OUTER_LIMIT    = 65535;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_LIMIT     = 3000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int REPORT_LIMIT   = 10;

    // No register sits at this index; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 16'sh8000;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic                     tensor_done;
    } t_mean_result;

    // Scoreboard: tracks the tensor walk, keeps one running sum per inner
    // position and queues the means that the block has to produce.
    class mean_predictor;
        int unsigned  inner_len, avg_count, outer_len;
        int unsigned  inner_pos, reduced_pos, outer_pos;
        longint       sums [INNER_LIMIT];
        t_mean_result pending_means [$];
        int           mismatches;
        int           means_seen;

        function new();
            inner_len   = 1;
            avg_count   = 1;
            outer_len   = 1;
            inner_pos   = 0;
            reduced_pos = 0;
            outer_pos   = 0;
            mismatches  = 0;
            means_seen  = 0;
        endfunction

        // A zero size acts as one; oversized values saturate.
        function int unsigned clamp_size(int unsigned value, int unsigned top);
            if (value == 0) return 1;
            return (value > top) ? top : value;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INNER: inner_len  = clamp_size(data[INNER_CFG_W-1:0], INNER_LIMIT);
                CFG_COUNT: avg_count  = clamp_size(data[COUNT_CFG_W-1:0], COUNT_LIMIT);
                CFG_OUTER: outer_len  = clamp_size(data[OUTER_CFG_W-1:0], OUTER_LIMIT);
                default:   return;
            endcase
            // Any real register write starts a new tensor.
            inner_pos   = 0;
            reduced_pos = 0;
            outer_pos   = 0;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] sample);
            logic         last_inner, last_reduced, last_outer;
            t_mean_result mean_out;
            // The first reduced slice overwrites the sum, later ones add.
            if (reduced_pos == 0) sums[inner_pos] = sample;
            else sums[inner_pos] += sample;
            last_inner   = (inner_pos + 1 >= inner_len);
            last_reduced = (reduced_pos + 1 >= avg_count);
            last_outer   = (outer_pos + 1 >= outer_len);
            if (last_reduced) begin
                mean_out.mean        = sums[inner_pos] / longint'(avg_count);
                mean_out.tensor_done = last_inner && last_outer;
                pending_means.push_back(mean_out);
            end
            // Inner position runs fastest, then reduced, then outer.
            if (!last_inner) begin
                inner_pos++;
            end else begin
                inner_pos = 0;
                if (!last_reduced) begin
                    reduced_pos++;
                end else begin
                    reduced_pos = 0;
                    outer_pos   = last_outer ? 0 : outer_pos + 1;
                end
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void check_mean(logic signed [MEAN_W-1:0] mean, logic tensor_done);
            t_mean_result want;
            means_seen++;
            if (pending_means.size() == 0) begin
                report($sformatf("mean %0d (done %0b) arrived with none expected",
                                 mean, tensor_done));
            end else begin
                want = pending_means.pop_front();
                if (mean !== want.mean || tensor_done !== want.tensor_done) begin
                    report($sformatf({"mismatch on mean %0d: expected %0d done %0b, ",
                                      "got %0d done %0b"},
                                     means_seen, want.mean, want.tensor_done, mean,
                                     tensor_done));
                end
            end
        endfunction
    endclass

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample      = '0;
    logic                       o_valid;
    logic                       i_stall       = 1'b0;
    logic signed [MEAN_W-1:0]   o_mean;
    logic                       o_tensor_done;
    logic                       i_cfg_valid   = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data    = '0;

    mean_predictor pred;

    bit feed_calm    = 1'b0;
    bit sink_calm    = 1'b0;
    bit squeeze_req  = 1'b0;
    int sink_hold    = 0;
    int squeeze_left = 0;
    int idle_cycles  = 0;

    tensor_axis_mean_reducer_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Result side: after each transaction draw how long to stall the next
    // valid result; a squeeze request stalls for a long fixed stretch.
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && !i_stall) begin
            if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
            sink_hold = sink_calm ? 0 : $urandom_range(0, 5);
        end else if (o_valid === 1'b1 && sink_hold > 0) begin
            sink_hold--;
        end
        if (squeeze_req) begin
            squeeze_left = SQUEEZE_CYCLES;
            squeeze_req  = 1'b0;
        end else if (squeeze_left > 0) begin
            squeeze_left--;
        end
        i_stall <= (sink_hold > 0) || (squeeze_left > 0);
    end

    // Observe every transaction on the three channels and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (o_valid === 1'b1 && !i_stall) begin
                pred.check_mean(o_mean, o_tensor_done);
                idle_cycles = 0;
            end
            if (i_valid && o_stall === 1'b0) begin
                pred.note_sample(i_sample);
                idle_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                pred.write_reg(i_cfg_index, i_cfg_data);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one sample after a random gap and wait for its transaction.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
        int gap;
        if ($urandom_range(0, 29) == 0) feed_calm = !feed_calm;
        gap = feed_calm ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= sample;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Leaves the write valid raised so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic load_sizes(input logic [CFG_DATA_W-1:0] inner_d, count_d, outer_d);
        write_reg(CFG_OUTER, outer_d);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_COUNT, count_d);
        write_reg(CFG_INNER, inner_d);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every predicted mean has arrived and the divider is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pred.pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit low_heavy);
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (low_heavy) return (roll == 0) ? SAMPLE_W'($urandom) : SAMPLE_BOTTOM;
        if (roll == 0) return SAMPLE_TOP;
        if (roll == 1) return SAMPLE_BOTTOM;
        return SAMPLE_W'($urandom);
    endfunction

    // One setting: load the sizes (or only poke the unused index, which must
    // keep the tensor walk going), then stream random samples and drain.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] inner_d, count_d, outer_d,
                             input int items, input bit load, input bit low_heavy);
        if (load) begin
            load_sizes(inner_d, count_d, outer_d);
        end else begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;
        end
        repeat (items) send_sample(pick_sample(low_heavy));
        drain();
    endtask

    initial begin
        pred = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes are all one: every sample is its own mean and ends a tensor.
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain();

        // Zero in every size register behaves as one.
        load_sizes(16'd0, 16'd0, 16'd0);
        send_sample(16'sd3);
        drain();

        // Two of each axis; negative halves truncate toward zero.
        load_sizes(16'd2, 16'd2, 16'd2);
        send_sample(-16'sd3);
        send_sample(16'sd3);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        drain();

        // Data bits above each register width are dropped.
        load_sizes(16'hFE03, 16'hF802, 16'h0001);
        send_sample(-16'sd7);
        send_sample(16'sd5);
        send_sample(16'sd1);
        send_sample(16'sd2);
        send_sample(-16'sd9);
        send_sample(SAMPLE_TOP);
        drain();

        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 3)),
                  16'($urandom_range(1, 3)), 40, 1'b1, 1'b0);

        // Widest inner size, no averaging, endless outer range; the long
        // output stall lets the block fill up and hold off the input.
        squeeze_req = 1'b1;
        run_phase(16'h01FF, 16'd1, 16'hFFFF, 60, 1'b1, 1'b0);

        // A deep average of mostly the most negative sample drives the
        // running sum far beyond the sample range.
        run_phase(16'd1, 16'd128, 16'd1, 128, 1'b1, 1'b1);

        // Oversized count saturates to the deepest average, which this
        // short stretch never completes, so no mean may appear.
        run_phase(16'd1, 16'h07FF, 16'd1, 40, 1'b1, 1'b1);

        // Stop mid-tensor, poke the unused index, and carry on.
        run_phase(16'd3, 16'd2, 16'd5, 17, 1'b1, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 25, 1'b0, 1'b0);

        run_phase(16'h0100, 16'd1, 16'd2, 30, 1'b1, 1'b0);
        repeat (4) begin
            run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 4)),
                      16'($urandom_range(1, 3)), 20, 1'b1, 1'b0);
        end

        if (pred.mismatches == 0 && pred.pending_means.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
